>>> hw/rtl/sa_pkg.sv
`timescale 1ns / 1ps

package sa_pkg;

  // Fixed field widths
  localparam int SAMPLE_W   = 32;
  localparam int PERIOD_W   = 9;
  localparam int IDX_W      = 10;  // enough for the largest slot count
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NODATA_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NODATA_VALUE  = 2'd2;

  // Item kinds
  localparam logic KIND_ACC  = 1'b0;
  localparam logic KIND_EMIT = 1'b1;

  // Register reset values and limits
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 9'd12;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 9'd2;

  // -9999.0 in Q16.16
  localparam logic signed [SAMPLE_W-1:0] NODATA_OUT = 32'shD8F1_0000;

  // Command handed from the front end to the back end
  typedef struct packed {
    logic                       kind;
    logic                       first;     // overwrite slot instead of adding
    logic                       clr_ovf;   // new series: clear sticky overflow
    logic                       nodata;
    logic [IDX_W-1:0]           idx;
    logic signed [SAMPLE_W-1:0] sample;
  } sa_cmd_t;

endpackage

>>> hw/rtl/sa_front.sv
`timescale 1ns / 1ps

module sa_front import sa_pkg::*; #(
  parameter int PHASE_SLOTS = 512,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       kind,
  input  logic                       start_req,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       push_valid,
  input  logic                       push_ready,
  output sa_cmd_t                    push_cmd
);

  localparam int PW    = $clog2(PHASE_SLOTS);
  localparam int SLW   = $clog2(PHASE_SLOTS + 1);
  localparam int CMP_W = (SLW > PERIOD_W) ? SLW : PERIOD_W;

  logic [PERIOD_W-1:0]        period;
  logic                       nodata_enable;
  logic signed [SAMPLE_W-1:0] nodata_value;

  logic [PW-1:0]              phase_index;
  logic                       first_cycle;

  logic                       accept;
  logic                       restart_series;
  logic [PW-1:0]              phase_cur;
  logic [PW-1:0]              phase_next;
  logic                       first_eff;
  logic                       first_next;
  logic [CMP_W-1:0]           eff_period;
  logic [CMP_W-1:0]           step;
  logic signed [SAMPLE_W-1:0] sample_ext;
  logic                       is_nd;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      period        <= PERIOD_RESET;
      nodata_enable <= 1'b0;
      nodata_value  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PERIOD:        period        <= cfg_data[PERIOD_W-1:0];
        REG_NODATA_ENABLE: nodata_enable <= cfg_data[0];
        REG_NODATA_VALUE:  nodata_value  <= signed'(cfg_data[SAMPLE_W-1:0]);
        default: ;
      endcase
    end
  end

  // Classify the item: phase, first-cycle mode, nodata
  always_comb begin
    sample_ext     = SAMPLE_W'(signed'(sample[SAMPLE_BITS-1:0]));
    is_nd          = nodata_enable && (sample_ext == nodata_value);
    restart_series = start_req && (kind == KIND_ACC);
    phase_cur      = start_req ? '0 : phase_index;
    first_eff      = restart_series ? 1'b1 : first_cycle;

    if (period < PERIOD_MIN) begin
      eff_period = CMP_W'(PERIOD_MIN);
    end else if (CMP_W'(period) > CMP_W'(PHASE_SLOTS)) begin
      eff_period = CMP_W'(PHASE_SLOTS);
    end else begin
      eff_period = CMP_W'(period);
    end

    // phase steps modulo the period; an accumulate wrap ends the first cycle
    step = CMP_W'(phase_cur) + CMP_W'(1);
    if (step >= eff_period) begin
      phase_next = '0;
      first_next = (kind == KIND_ACC) ? 1'b0 : first_eff;
    end else begin
      phase_next = step[PW-1:0];
      first_next = first_eff;
    end

    push_cmd.kind    = kind;
    push_cmd.first   = first_eff;
    push_cmd.clr_ovf = restart_series;
    push_cmd.nodata  = is_nd;
    push_cmd.idx     = IDX_W'(phase_cur);
    push_cmd.sample  = sample_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_index <= '0;
      first_cycle <= 1'b1;
    end else if (accept) begin
      phase_index <= phase_next;
      first_cycle <= first_next;
    end
  end

endmodule

>>> hw/rtl/sa_queue.sv
`timescale 1ns / 1ps

module sa_queue import sa_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push_valid,
  output logic    push_ready,
  input  sa_cmd_t push_cmd,
  output logic    pop_valid,
  input  logic    pop_ready,
  output sa_cmd_t pop_cmd
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  sa_cmd_t            entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> hw/rtl/sa_div.sv
`timescale 1ns / 1ps

module sa_div import sa_pkg::*; #(
  parameter int SUM_W      = 48,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [SUM_W-1:0]      dividend,
  input  logic [COUNT_BITS-1:0] divisor,
  output logic                  done,
  output logic [SUM_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]      dq;
  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS-1:0] dvs;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic [COUNT_BITS:0]   shifted;
  logic                  fits;

  assign quotient = dq;

  // One restoring step: bring down the next dividend bit, try the subtract
  always_comb begin
    shifted = {rem, dq[SUM_W-1]};
    fits    = (shifted >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= COUNT_BITS'(shifted - {1'b0, dvs});
      end else begin
        rem <= shifted[COUNT_BITS-1:0];
      end
      dq <= {dq[SUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(SUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/sa_back.sv
`timescale 1ns / 1ps

module sa_back import sa_pkg::*; #(
  parameter int PHASE_SLOTS = 512,
  parameter int SAMPLE_BITS = 32,
  parameter int COUNT_BITS  = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  sa_cmd_t                    q_cmd,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] anomaly,
  output logic                       is_nodata,
  output logic                       overflow
);

  localparam int PW     = $clog2(PHASE_SLOTS);
  localparam int SUM_W  = SAMPLE_BITS + COUNT_BITS;
  localparam int DIFF_W = ((SUM_W > SAMPLE_W) ? SUM_W : SAMPLE_W) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]                 state;
  sa_cmd_t                    cmd;
  logic                       ovf;

  logic signed [SUM_W-1:0]    sum_mem   [PHASE_SLOTS];
  logic [COUNT_BITS-1:0]      count_mem [PHASE_SLOTS];
  logic signed [SUM_W-1:0]    sum_rd;
  logic [COUNT_BITS-1:0]      count_rd;
  logic [PW-1:0]              addr;

  logic                       mem_we;
  logic signed [SUM_W-1:0]    wr_sum;
  logic [COUNT_BITS-1:0]      wr_count;
  logic                       ovf_set;
  logic signed [SUM_W-1:0]    s_sum;

  logic                       div_start;
  logic                       div_done;
  logic [SUM_W-1:0]           div_mag;
  logic [SUM_W-1:0]           div_q;
  logic                       sum_neg;
  logic signed [SUM_W-1:0]    mean_reg;

  logic signed [DIFF_W-1:0]   diff;
  logic [DIFF_W-SAMPLE_W:0]   diff_hi;
  logic signed [SAMPLE_W-1:0] res_anom;
  logic                       load_out;

  assign q_ready  = (state == S_IDLE);
  assign addr     = cmd.idx[PW-1:0];
  assign s_sum    = SUM_W'(cmd.sample);
  assign load_out = (state == S_OUT) && (!out_valid || out_ready);

  // Slot update for accumulate items
  always_comb begin
    mem_we   = 1'b0;
    ovf_set  = 1'b0;
    wr_sum   = s_sum;
    wr_count = COUNT_BITS'(1);
    if (state == S_EXEC && cmd.kind == KIND_ACC) begin
      if (cmd.first) begin
        mem_we   = 1'b1;
        wr_sum   = cmd.nodata ? '0 : s_sum;
        wr_count = cmd.nodata ? '0 : COUNT_BITS'(1);
      end else if (!cmd.nodata) begin
        if (count_rd == {COUNT_BITS{1'b1}}) begin
          ovf_set = 1'b1;
        end else begin
          mem_we   = 1'b1;
          wr_sum   = sum_rd + s_sum;
          wr_count = count_rd + COUNT_BITS'(1);
        end
      end
    end
  end

  // Per-phase sum and count memories, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      sum_mem[addr]   <= wr_sum;
      count_mem[addr] <= wr_count;
    end
    sum_rd   <= sum_mem[addr];
    count_rd <= count_mem[addr];
  end

  // Mean by magnitude division, sign restored afterwards
  assign div_start = (state == S_EXEC) && (cmd.kind == KIND_EMIT) && !cmd.nodata
                     && (count_rd != '0);
  assign div_mag   = sum_rd[SUM_W-1] ? unsigned'(-sum_rd) : unsigned'(sum_rd);

  sa_div #(
    .SUM_W      (SUM_W),
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_mag),
    .divisor  (count_rd),
    .done     (div_done),
    .quotient (div_q)
  );

  // Anomaly with saturation to 32 bits
  always_comb begin
    diff    = DIFF_W'(cmd.sample) - DIFF_W'(mean_reg);
    diff_hi = diff[DIFF_W-1:SAMPLE_W-1];
    if (cmd.nodata) begin
      res_anom = NODATA_OUT;
    end else if (diff_hi == '0 || diff_hi == '1) begin
      res_anom = diff[SAMPLE_W-1:0];
    end else if (diff[DIFF_W-1]) begin
      res_anom = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      res_anom = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ovf   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_cmd.clr_ovf) begin
              ovf <= 1'b0;
            end
            state <= S_READ;
          end
        end
        S_READ: state <= S_EXEC;
        S_EXEC: begin
          if (cmd.kind == KIND_ACC) begin
            if (ovf_set) begin
              ovf <= 1'b1;
            end
            state <= S_IDLE;
          end else if (div_start) begin
            state <= S_DIV;
          end else begin
            state <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Command and mean registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) begin
      cmd <= q_cmd;
    end
    if (state == S_EXEC) begin
      sum_neg  <= sum_rd[SUM_W-1];
      mean_reg <= '0;
    end else if (state == S_DIV && div_done) begin
      mean_reg <= sum_neg ? -signed'(div_q) : signed'(div_q);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Sticky flag is captured with the result so it holds while stalled
  always_ff @(posedge clk) begin
    if (load_out) begin
      anomaly   <= res_anom;
      is_nodata <= cmd.nodata;
      overflow  <= ovf;
    end
  end

  // Checks
  a_no_write_in_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> !mem_we)
    else $error("slot written while divider runs");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide state");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && !out_ready) |=> (state == S_OUT))
    else $error("result dropped while output is stalled");

  a_ovf_source: assert property (@(posedge clk) disable iff (rst)
    $rose(ovf) |-> ($past(state) == S_EXEC))
    else $error("overflow set outside an accumulate update");

endmodule

>>> hw/rtl/seasonal_anomaly_unit.sv
`timescale 1ns / 1ps
// Seasonal mean removal for one pixel's time series.
// Input channel (in_valid/in_ready): kind, start_req, sample. An accumulate
// item (kind 0) adds the sample to the sum and count of the current phase;
// an emit item (kind 1) returns sample minus the truncated phase mean on the
// output channel (out_valid/out_ready): anomaly, is_nodata, overflow.
// Config port: cfg_we, cfg_index (0 period, 1 nodata_enable, 2 nodata_value),
// cfg_data; write only while no item is in flight.
// The front end classifies items and queues them (two entries); the back end
// runs them against the per-phase memories one at a time.
// Accumulate: the back end picks up the item, reads the memory, then does the
// read-modify-write. Emit: the back end picks up the item, reads the memory,
// runs the bit-per-cycle mean divider and loads the result; nodata or
// empty-slot emits skip the divider.
// Reset: phase 0, first cycle set, overflow clear, registers at defaults;
// memories need no clearing since the first cycle of a series overwrites.
// A stalled receiver holds the result; accumulates keep running until a second
// emit needs the output register, and the queue keeps taking items until full.
module seasonal_anomaly_unit import sa_pkg::*; #(
  parameter int PHASE_SLOTS = 512,
  parameter int SAMPLE_BITS = 32,
  parameter int COUNT_BITS  = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       kind,
  input  logic                       start_req,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] anomaly,
  output logic                       is_nodata,
  output logic                       overflow
);

  logic    push_valid;
  logic    push_ready;
  sa_cmd_t push_cmd;
  logic    pop_valid;
  logic    pop_ready;
  sa_cmd_t pop_cmd;

  sa_front #(
    .PHASE_SLOTS (PHASE_SLOTS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .start_req  (start_req),
    .sample     (sample),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  sa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  sa_back #(
    .PHASE_SLOTS (PHASE_SLOTS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_cmd     (pop_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .anomaly   (anomaly),
    .is_nodata (is_nodata),
    .overflow  (overflow)
  );

endmodule
